FILE: hdl/tecp_pkg.sv
// Package for the text escape cursor parser: glyph geometry, character codes,
// color selection codes, reset colors and the result types shared by all modules.
// No dependencies.
package tecp_pkg;

    // Glyph cell and screen geometry in pixels
    localparam int GLYPH_WIDTH   = 5;
    localparam int GLYPH_HEIGHT  = 8;
    localparam int SCREEN_WIDTH  = 96;
    localparam int SCREEN_HEIGHT = 64;

    // Cursor step after a glyph and row pitch of a row escape
    localparam int COL_STEP  = GLYPH_WIDTH + 1;
    localparam int ROW_PITCH = GLYPH_HEIGHT + 1;

    localparam int NUM_COLORS = 7;
    localparam int COLOR_W    = 16;
    localparam int CFG_IDX_W  = 3;

    // Character codes
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_ESC    = 8'h2F;  // slash
    localparam logic [7:0] CHAR_ROW_LO = 8'h30;  // '0'
    localparam logic [7:0] CHAR_ROW_HI = 8'h36;  // '6'
    localparam logic [7:0] CHAR_WHITE   = 8'h77; // 'w'
    localparam logic [7:0] CHAR_RED     = 8'h72; // 'r'
    localparam logic [7:0] CHAR_GREEN   = 8'h67; // 'g'
    localparam logic [7:0] CHAR_BLUE    = 8'h62; // 'b'
    localparam logic [7:0] CHAR_YELLOW  = 8'h79; // 'y'
    localparam logic [7:0] CHAR_CYAN    = 8'h63; // 'c'
    localparam logic [7:0] CHAR_MAGENTA = 8'h6D; // 'm'

    // Color selection; also the configuration register index
    typedef enum logic [CFG_IDX_W-1:0] {
        COLOR_WHITE   = 3'd0,
        COLOR_RED     = 3'd1,
        COLOR_GREEN   = 3'd2,
        COLOR_BLUE    = 3'd3,
        COLOR_YELLOW  = 3'd4,
        COLOR_CYAN    = 3'd5,
        COLOR_MAGENTA = 3'd6
    } color_sel_t;

    typedef logic [COLOR_W-1:0] color_t;

    localparam color_t COLOR_RESET [NUM_COLORS] = '{
        16'd65535, 16'd2016, 16'd31, 16'd63488, 16'd2047, 16'd63519, 16'd65504
    };

    // Escape letter lookup result
    typedef struct packed {
        logic       hit;
        color_sel_t sel;
    } color_hit_t;

    // Glyph cell produced by the parser for one printable byte
    typedef struct packed {
        logic [7:0] glyph_code;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic       cell_fits;
    } glyph_cell_t;

    // Full result word held in the output stage
    typedef struct packed {
        logic [7:0] glyph_code;
        color_t     glyph_color;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic       cell_fits;
    } result_t;

    // Map an escape letter to a color selection
    function automatic color_hit_t color_letter(input logic [7:0] ch);
        color_hit_t r;
        r.hit = 1'b1;
        case (ch)
            CHAR_WHITE:   r.sel = COLOR_WHITE;
            CHAR_RED:     r.sel = COLOR_RED;
            CHAR_GREEN:   r.sel = COLOR_GREEN;
            CHAR_BLUE:    r.sel = COLOR_BLUE;
            CHAR_YELLOW:  r.sel = COLOR_YELLOW;
            CHAR_CYAN:    r.sel = COLOR_CYAN;
            CHAR_MAGENTA: r.sel = COLOR_MAGENTA;
            default:
            begin
                r.hit = 1'b0;
                r.sel = COLOR_WHITE;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/tecp_if.sv
// Channel interfaces of the text escape cursor parser: text input, glyph
// output and configuration write. Depends on tecp_pkg.

interface tecp_text_if;
    import tecp_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       start_of_text;

    modport source (output valid, output char_code, output start_of_text, input ready);
    modport sink   (input valid, input char_code, input start_of_text, output ready);
endinterface

interface tecp_glyph_if;
    import tecp_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] glyph_code;
    color_t     glyph_color;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic       cell_fits;

    modport source (output valid, output glyph_code, output glyph_color, output cell_x,
                    output cell_y, output cell_fits, input ready);
    modport sink   (input valid, input glyph_code, input glyph_color, input cell_x,
                    input cell_y, input cell_fits, output ready);
endinterface

interface tecp_cfg_if;
    import tecp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    color_t               data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/tecp_color_bank.sv
// Color register bank: seven 16-bit colors written over the configuration
// channel and read by the current color selection. Depends on tecp_pkg, tecp_if.
module tecp_color_bank
    import tecp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    tecp_cfg_if.sink        cfg,
    input  color_sel_t      sel,
    output color_t          color
);

    color_t color_reg [NUM_COLORS];

    // Always ready for a configuration word
    assign cfg.ready = 1'b1;

    // Write the addressed register; drop indexes past the last color
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= COLOR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                COLOR_WHITE:   color_reg[COLOR_WHITE]   <= cfg.data;
                COLOR_RED:     color_reg[COLOR_RED]     <= cfg.data;
                COLOR_GREEN:   color_reg[COLOR_GREEN]   <= cfg.data;
                COLOR_BLUE:    color_reg[COLOR_BLUE]    <= cfg.data;
                COLOR_YELLOW:  color_reg[COLOR_YELLOW]  <= cfg.data;
                COLOR_CYAN:    color_reg[COLOR_CYAN]    <= cfg.data;
                COLOR_MAGENTA: color_reg[COLOR_MAGENTA] <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Select the current color
    always_comb
    begin
        case (sel)
            COLOR_WHITE:   color = color_reg[COLOR_WHITE];
            COLOR_RED:     color = color_reg[COLOR_RED];
            COLOR_GREEN:   color = color_reg[COLOR_GREEN];
            COLOR_BLUE:    color = color_reg[COLOR_BLUE];
            COLOR_YELLOW:  color = color_reg[COLOR_YELLOW];
            COLOR_CYAN:    color = color_reg[COLOR_CYAN];
            COLOR_MAGENTA: color = color_reg[COLOR_MAGENTA];
            default:       color = color_reg[COLOR_WHITE];
        endcase
    end

endmodule

FILE: hdl/tecp_parser.sv
// Escape parser and cursor state: decodes one accepted text byte per cycle, updates
// escape, color and cursor state, and forms the glyph cell. Depends on tecp_pkg.
module tecp_parser
    import tecp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  char_code,
    input  logic        start_of_text,
    output logic        emit,
    output glyph_cell_t glyph_cell,
    output color_sel_t  sel
);

    logic       esc_reg, esc_next, esc_eff;
    color_sel_t sel_reg, sel_next, sel_eff;
    logic [7:0] x_reg, x_next, x_eff;
    logic [7:0] y_reg, y_next, y_eff;
    logic [2:0] row_idx;
    color_hit_t letter;
    logic [8:0] right_edge;
    logic [8:0] bottom_edge;

    // Apply start of text before the byte is handled
    assign esc_eff = start_of_text ? 1'b0 : esc_reg;
    assign sel_eff = start_of_text ? COLOR_WHITE : sel_reg;
    assign x_eff   = start_of_text ? 8'd0 : x_reg;
    assign y_eff   = start_of_text ? 8'd0 : y_reg;

    assign row_idx = 3'(char_code - CHAR_ROW_LO);
    assign letter  = color_letter(char_code);

    // Decode the byte and compute next state
    always_comb
    begin
        esc_next = esc_eff;
        sel_next = sel_eff;
        x_next   = x_eff;
        y_next   = y_eff;
        emit     = 1'b0;
        if (char_code == CHAR_NUL)
        begin
            esc_next = 1'b0;
        end
        else if (esc_eff)
        begin
            esc_next = 1'b0;
            if (char_code == CHAR_ESC)
            begin
                emit = 1'b1;
            end
            else if (char_code inside {[CHAR_ROW_LO:CHAR_ROW_HI]})
            begin
                x_next = 8'd0;
                y_next = 8'(ROW_PITCH * int'(row_idx));
            end
            else if (letter.hit)
            begin
                sel_next = letter.sel;
            end
        end
        else if (char_code == CHAR_ESC)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            emit = 1'b1;
        end
        if (emit)
        begin
            x_next = x_eff + 8'(COL_STEP);
        end
    end

    // Form the glyph cell at the current cursor
    assign right_edge  = {1'b0, x_eff} + 9'(GLYPH_WIDTH);
    assign bottom_edge = {1'b0, y_eff} + 9'(GLYPH_HEIGHT);

    always_comb
    begin
        glyph_cell.glyph_code = char_code;
        glyph_cell.cell_x     = x_eff;
        glyph_cell.cell_y     = y_eff;
        glyph_cell.cell_fits  = (right_edge <= 9'(SCREEN_WIDTH))
                             && (bottom_edge <= 9'(SCREEN_HEIGHT));
    end

    assign sel = sel_eff;

    // Advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
            sel_reg <= COLOR_WHITE;
            x_reg   <= 8'd0;
            y_reg   <= 8'd0;
        end
        else if (accept)
        begin
            esc_reg <= esc_next;
            sel_reg <= sel_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

endmodule

FILE: hdl/tecp_out_stage.sv
// Output register with a skid entry: holds results while the sink stalls and
// keeps input acceptance off the output ready path. Depends on tecp_pkg.
module tecp_out_stage
    import tecp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_data,
    output logic    space
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_fire;

    assign out_fire = out_valid_reg && out_ready;

    // Fill the output register first, the skid entry when it stalls
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (load && (!out_valid_reg || out_fire))
        begin
            out_data_next  = load_data;
            out_valid_next = 1'b1;
        end
        else if (load)
        begin
            skid_data_next  = load_data;
            skid_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign space     = !skid_valid_reg;

endmodule

FILE: hdl/text_escape_cursor_parser.sv
// Top level of the text escape cursor parser: parser, color bank and output
// stage. Depends on tecp_pkg, tecp_if, tecp_parser, tecp_color_bank, tecp_out_stage.
//
//  Channel    Dir  Payload                                             Accept
//  text_in    in   char_code[7:0], start_of_text                       valid & ready
//  glyph_out  out  glyph_code[7:0], glyph_color[15:0], cell_x, cell_y,
//                  cell_fits                                           valid & ready
//  cfg        in   index[2:0], data[15:0]                              valid & ready
//
// One text word per cycle while text_in.ready is high; a printable word is
// registered for glyph_out. The output register plus one skid entry lets text_in
// keep accepting into an output stall; text_in.ready drops only when both are
// full. cfg is always ready. Reset restores the colors and clears cursor, color
// choice and escape state; no clearing pass is needed.
module text_escape_cursor_parser
    import tecp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tecp_text_if.sink    text_in,
    tecp_glyph_if.source glyph_out,
    tecp_cfg_if.sink     cfg
);

    logic        accept;
    logic        emit;
    logic        load;
    logic        space;
    logic        out_valid;
    glyph_cell_t glyph_cell;
    color_sel_t  sel;
    color_t      color;
    result_t     load_data;
    result_t     out_data;

    assign text_in.ready = space;
    assign accept        = text_in.valid && space;
    assign load          = accept && emit;

    tecp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .char_code     (text_in.char_code),
        .start_of_text (text_in.start_of_text),
        .emit          (emit),
        .glyph_cell    (glyph_cell),
        .sel           (sel)
    );

    tecp_color_bank u_color_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .sel   (sel),
        .color (color)
    );

    // Join the cell with its color
    always_comb
    begin
        load_data.glyph_code  = glyph_cell.glyph_code;
        load_data.glyph_color = color;
        load_data.cell_x      = glyph_cell.cell_x;
        load_data.cell_y      = glyph_cell.cell_y;
        load_data.cell_fits   = glyph_cell.cell_fits;
    end

    tecp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (load_data),
        .out_ready (glyph_out.ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .space     (space)
    );

    assign glyph_out.valid       = out_valid;
    assign glyph_out.glyph_code  = out_data.glyph_code;
    assign glyph_out.glyph_color = out_data.glyph_color;
    assign glyph_out.cell_x      = out_data.cell_x;
    assign glyph_out.cell_y      = out_data.cell_y;
    assign glyph_out.cell_fits   = out_data.cell_fits;

`ifndef SYNTHESIS
    // A full skid entry implies the output register is full
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        !space |-> out_valid)
        else $error("skid entry full while output register empty");

    // A terminator never yields a result
    a_nul_silent: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> text_in.char_code != CHAR_NUL)
        else $error("result loaded for a terminator byte");

    // A stalled result stays presented
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !glyph_out.ready |=> out_valid)
        else $error("result dropped while stalled");

    // After a load, the output register holds a valid result the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("loaded result not presented");
`endif

endmodule
